// ----- src/pakf_pkg.sv -----
package pakf_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int ANG_W        = 16;
	localparam int VAR_W        = 32;
	localparam int SLOPE_W      = 32;
	localparam int GAIN_W       = 17;
	localparam int DIV_STEPS    = GAIN_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;
	localparam int OUT_DATA_W   = 2 * ANG_W + VAR_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ADC_ORIGIN   = 3'd0,
		CFG_SLOPE        = 3'd1,
		CFG_ANGLE_OFFSET = 3'd2,
		CFG_MEAS_VAR     = 3'd3,
		CFG_PROC_VAR     = 3'd4,
		CFG_INIT_VAR     = 3'd5
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP,
		ST_RAW,
		ST_PRED,
		ST_DINIT,
		ST_DIV,
		ST_MULE,
		ST_MULV,
		ST_UPD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic load;
		logic map;
		logic raw;
		logic pred;
		logic dinit;
		logic dstep;
		logic mule;
		logic mulv;
		logic upd;
		logic oload;
	} cmd_t;

	typedef struct packed {
		logic div_last;
	} stat_t;

endpackage

// ----- src/pakf_ctrl.sv -----
module pakf_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  pakf_pkg::stat_t stat,
	output pakf_pkg::cmd_t  cmd
);
	import pakf_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nxt = ST_MAP;
			ST_MAP:   state_nxt = ST_RAW;
			ST_RAW:   state_nxt = ST_PRED;
			ST_PRED:  state_nxt = ST_DINIT;
			ST_DINIT: state_nxt = ST_DIV;
			ST_DIV:   if (stat.div_last) state_nxt = ST_MULE;
			ST_MULE:  state_nxt = ST_MULV;
			ST_MULV:  state_nxt = ST_UPD;
			ST_UPD:   state_nxt = ST_OUT;
			ST_OUT:   if (out_free) state_nxt = ST_IDLE;
			default:  state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_MAP:   cmd.map   = 1'b1;
			ST_RAW:   cmd.raw   = 1'b1;
			ST_PRED:  cmd.pred  = 1'b1;
			ST_DINIT: cmd.dinit = 1'b1;
			ST_DIV:   cmd.dstep = 1'b1;
			ST_MULE:  cmd.mule  = 1'b1;
			ST_MULV:  cmd.mulv  = 1'b1;
			ST_UPD:   cmd.upd   = 1'b1;
			ST_OUT:   cmd.oload = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			// a new result replaces a taken one in the same cycle
			if (cmd.oload)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- src/pakf_dp.sv -----
module pakf_dp #(
	parameter int ADC_BITS = pakf_pkg::ADC_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [ADC_BITS-1:0]             sample,
	input  logic                            cfg_we,
	input  logic [pakf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pakf_pkg::CFG_DATA_W-1:0] cfg_data,
	input  pakf_pkg::cmd_t                  cmd,
	output pakf_pkg::stat_t                 stat,
	output logic [pakf_pkg::OUT_DATA_W-1:0] out_data
);
	import pakf_pkg::*;

	localparam int DIFF_W = ADC_BITS + 1;
	localparam int PROD_W = DIFF_W + SLOPE_W;
	localparam int ACC_W  = PROD_W + 1;
	localparam int REM_W  = VAR_W + 2;
	localparam int ERR_W  = ANG_W + 1;
	localparam int MULE_W = ERR_W + GAIN_W + 1;
	localparam int MULV_W = VAR_W + GAIN_W;
	localparam int SUME_W = ANG_W + 4;

	localparam logic signed [ACC_W-1:0]  ACC_MAX = ACC_W'(32767);
	localparam logic signed [ACC_W-1:0]  ACC_MIN = -ACC_W'(32768);
	localparam logic signed [SUME_W-1:0] EST_MAX = SUME_W'(32767);
	localparam logic signed [SUME_W-1:0] EST_MIN = -SUME_W'(32768);
	localparam logic [GAIN_W-1:0]        GAIN_ONE = GAIN_W'(65536);

	// configuration registers
	logic        [ADC_BITS-1:0] origin_q;
	logic signed [SLOPE_W-1:0]  slope_q;
	logic signed [ANG_W-1:0]    offset_q;
	logic        [VAR_W-1:0]    meas_q;
	logic        [VAR_W-1:0]    proc_q;
	logic        [VAR_W-1:0]    init_q;

	// filter state
	logic signed [ANG_W-1:0] est_q;
	logic        [VAR_W-1:0] var_q;
	logic                    seeded_q;

	// working registers
	logic        [ADC_BITS-1:0]  sample_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [ANG_W-1:0]     raw_q;
	logic        [VAR_W-1:0]     p_q;
	logic        [REM_W-1:0]     rem_q;
	logic        [REM_W-1:0]     den_q;
	logic        [GAIN_W-1:0]    dsh_q;
	logic        [GAIN_W-1:0]    quot_q;
	logic        [DIV_CNT_W-1:0] cnt_q;
	logic                        dz_q;
	logic signed [MULE_W-1:0]    mule_q;
	logic        [MULV_W-1:0]    mulv_q;

	logic [ANG_W-1:0] o_est_q;
	logic [ANG_W-1:0] o_raw_q;
	logic [VAR_W-1:0] o_var_q;

	logic signed [DIFF_W-1:0] diff_w;
	logic signed [ACC_W-1:0]  acc_w;
	logic signed [ACC_W-1:0]  rsh_w;
	logic signed [ANG_W-1:0]  raw_sat_w;
	logic        [VAR_W:0]    psum_w;
	logic        [REM_W-1:0]  trial_w;
	logic        [GAIN_W-1:0] k_w;
	logic        [GAIN_W-1:0] kc_w;
	logic signed [ERR_W-1:0]  err_w;
	logic signed [MULE_W-1:0] stp_w;
	logic signed [SUME_W-1:0] sum_e_w;
	logic signed [ANG_W-1:0]  est_new_w;
	logic        [MULV_W-1:0] vr_w;

	always_comb begin
		diff_w = $signed({1'b0, sample_q}) - $signed({1'b0, origin_q});
		acc_w  = ACC_W'(prod_q) + (ACC_W'(offset_q) <<< 12);
		// round half up to q3.12
		rsh_w  = (acc_w + ACC_W'(2048)) >>> 12;
		if (rsh_w > ACC_MAX)
			raw_sat_w = 16'sh7fff;
		else if (rsh_w < ACC_MIN)
			raw_sat_w = -16'sh8000;
		else
			raw_sat_w = rsh_w[ANG_W-1:0];

		psum_w  = {1'b0, var_q} + {1'b0, proc_q};
		trial_w = {rem_q[REM_W-2:0], dsh_q[GAIN_W-1]};

		k_w  = dz_q ? '0 : quot_q;
		kc_w = GAIN_ONE - k_w;

		err_w = ERR_W'(raw_q) - ERR_W'(est_q);
		stp_w = (mule_q + MULE_W'(32768)) >>> 16;
		sum_e_w = SUME_W'(est_q) + SUME_W'(stp_w);
		if (sum_e_w > EST_MAX)
			est_new_w = 16'sh7fff;
		else if (sum_e_w < EST_MIN)
			est_new_w = -16'sh8000;
		else
			est_new_w = sum_e_w[ANG_W-1:0];

		vr_w = mulv_q + MULV_W'(32768);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			slope_q  <= '0;
			offset_q <= '0;
			meas_q   <= '0;
			proc_q   <= '0;
			init_q   <= VAR_W'(65536);
			est_q    <= '0;
			var_q    <= '0;
			seeded_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_index))
					CFG_ADC_ORIGIN:   origin_q <= cfg_data[ADC_BITS-1:0];
					CFG_SLOPE:        slope_q  <= cfg_data;
					CFG_ANGLE_OFFSET: offset_q <= cfg_data[ANG_W-1:0];
					CFG_MEAS_VAR:     meas_q   <= cfg_data;
					CFG_PROC_VAR:     proc_q   <= cfg_data;
					CFG_INIT_VAR:     init_q   <= cfg_data;
					default: ;
				endcase
			end
			// first sample seeds the filter
			if (cmd.raw && !seeded_q) begin
				est_q    <= raw_sat_w;
				var_q    <= init_q;
				seeded_q <= 1'b1;
			end
			if (cmd.dinit)
				cnt_q <= '0;
			else if (cmd.dstep)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.upd) begin
				est_q <= est_new_w;
				var_q <= vr_w[VAR_W+15:16];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			sample_q <= sample;
		if (cmd.map)
			prod_q <= diff_w * slope_q;
		if (cmd.raw)
			raw_q <= raw_sat_w;
		if (cmd.pred)
			p_q <= psum_w[VAR_W] ? '1 : psum_w[VAR_W-1:0];
		// gain = floor(p * 2^16 / (p + meas)), restoring, one bit a cycle
		if (cmd.dinit) begin
			den_q  <= REM_W'(p_q) + REM_W'(meas_q);
			rem_q  <= REM_W'(p_q >> 1);
			dsh_q  <= {p_q[0], {(GAIN_W-1){1'b0}}};
			quot_q <= '0;
			dz_q   <= (p_q == '0) && (meas_q == '0);
		end else if (cmd.dstep) begin
			dsh_q <= dsh_q << 1;
			if (trial_w >= den_q) begin
				rem_q  <= trial_w - den_q;
				quot_q <= {quot_q[GAIN_W-2:0], 1'b1};
			end else begin
				rem_q  <= trial_w;
				quot_q <= {quot_q[GAIN_W-2:0], 1'b0};
			end
		end
		if (cmd.mule)
			mule_q <= err_w * $signed({1'b0, k_w});
		if (cmd.mulv)
			mulv_q <= MULV_W'(p_q) * MULV_W'(kc_w);
		if (cmd.oload) begin
			o_est_q <= est_q;
			o_raw_q <= raw_q;
			o_var_q <= var_q;
		end
	end

	assign stat.div_last = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
	assign out_data      = {o_var_q, o_raw_q, o_est_q};

endmodule

// ----- src/pot_angle_kalman_filter.sv -----
// channel   beat fields (low bit up)                          handshake
// s_axis    tdata: adc_sample                                 tvalid/tready
// m_axis    tdata: filtered_angle, raw_angle, error_variance  tvalid/tready
// cfg       cfg_index, cfg_data                               cfg_valid/cfg_ready
//
// one sample in flight at a time: the next is taken once the last result is loaded
// the 17-step bit-serial gain divider takes up most of each sample's processing
// a result waits in the output register while the next sample is taken
// a stalled result side holds the filter in its last step until space frees
// reset clears the filter state and loads the register defaults
module pot_angle_kalman_filter #(
	parameter int ADC_BITS = pakf_pkg::ADC_BITS_DEF,
	parameter int IN_W     = ((ADC_BITS + 7) / 8) * 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [IN_W-1:0]                 s_axis_tdata,  // adc_sample
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// filtered_angle, raw_angle, error_variance
	output logic [pakf_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pakf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pakf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pakf_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	pakf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pakf_dp #(
		.ADC_BITS (ADC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (s_axis_tdata[ADC_BITS-1:0]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (m_axis_tdata)
	);

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.oload |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result overwritten before taken");

	// one sample in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("sample taken while busy");

	// divider stops after its last quotient bit
	a_div_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.dstep && stat.div_last) |=> (!cmd.dstep && cmd.mule))
		else $error("divider ran past its last step");

endmodule

// ----- tb/sv/pot_angle_kalman_filter_tb.sv -----
module pot_angle_kalman_filter_tb;
	import pakf_pkg::*;

	localparam int IN_W = ((ADC_BITS_DEF + 7) / 8) * 8;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
	localparam logic [31:0] VAR_MAX = 32'hFFFF_FFFF;
	localparam logic [31:0] VAR_ONE = 32'h0001_0000;
	localparam int PHASES = 6;

	typedef struct packed {
		logic signed [ANG_W-1:0] filt;
		logic signed [ANG_W-1:0] raw;
		logic [VAR_W-1:0]        err_var;
	} angle_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_W-1:0]       s_axis_tdata  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_valid     = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// calibration and noise settings as the block should hold them
	logic [ADC_BITS_DEF-1:0] cal_origin = '0;
	logic signed [31:0]      cal_slope  = '0;
	logic signed [15:0]      cal_offset = '0;
	logic [31:0]             noise_meas = '0;
	logic [31:0]             noise_proc = '0;
	logic [31:0]             var_init   = VAR_ONE;

	// filter state
	logic signed [15:0] est_q      = '0;
	logic [31:0]        est_var    = '0;
	bit                 est_seeded = 1'b0;

	angle_result_t pending_angles[$];
	int n_samples = 0;
	int n_results = 0;
	int n_writes  = 0;
	int n_bad     = 0;
	int src_idle_pct = 32;
	int snk_idle_pct = 70;

	pot_angle_kalman_filter u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
	end

	function automatic logic signed [15:0] sat_angle(input longint v);
		if (v > 32767)
			return 16'sh7FFF;
		if (v < -32768)
			return -16'sh8000;
		return v[15:0];
	endfunction

	function automatic angle_result_t kalman_update(input logic [ADC_BITS_DEF-1:0] sample);
		longint diff, acc, err, stp;
		longint unsigned p, denom, gain, nv;
		logic signed [15:0] raw;
		angle_result_t r;
		diff = $signed({1'b0, sample}) - $signed({1'b0, cal_origin});
		acc = diff * longint'(cal_slope) + longint'(cal_offset) * 4096;
		// q.24 to q3.12, ties go up
		raw = sat_angle((acc + 2048) >>> 12);
		if (!est_seeded) begin
			est_q = raw;
			est_var = var_init;
			est_seeded = 1'b1;
		end
		p = {32'd0, est_var} + {32'd0, noise_proc};
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		denom = p + {32'd0, noise_meas};
		gain = (denom == 0) ? 64'd0 : (p << 16) / denom;
		err = longint'(raw) - longint'(est_q);
		stp = (err * longint'(gain) + 32768) >>> 16;
		est_q = sat_angle(longint'(est_q) + stp);
		nv = (p * (64'd65536 - gain) + 64'd32768) >> 16;
		est_var = nv[31:0];
		r.filt = est_q;
		r.raw = raw;
		r.err_var = est_var;
		return r;
	endfunction

	task automatic report_bad(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("result %0d: %s expected %0h got %0h", n_results, what, want, got);
		n_bad++;
	endtask

	// one place for every handshake so that config, prediction and check stay ordered
	always @(posedge clk) begin
		angle_result_t want;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_angles.size() == 0) begin
					report_bad("beat with nothing pending", 64'd0, m_axis_tdata);
				end else begin
					want = pending_angles.pop_front();
					if (m_axis_tdata[15:0] !== want.filt)
						report_bad("filtered_angle", want.filt, m_axis_tdata[15:0]);
					if (m_axis_tdata[31:16] !== want.raw)
						report_bad("raw_angle", want.raw, m_axis_tdata[31:16]);
					if (m_axis_tdata[63:32] !== want.err_var)
						report_bad("error_variance", want.err_var, m_axis_tdata[63:32]);
				end
				n_results++;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ADC_ORIGIN:   cal_origin = cfg_data[ADC_BITS_DEF-1:0];
					CFG_SLOPE:        cal_slope  = cfg_data;
					CFG_ANGLE_OFFSET: cal_offset = cfg_data[15:0];
					CFG_MEAS_VAR:     noise_meas = cfg_data;
					CFG_PROC_VAR:     noise_proc = cfg_data;
					CFG_INIT_VAR:     var_init   = cfg_data;
					default: ;
				endcase
				n_writes++;
			end
			if (s_axis_tvalid && s_axis_tready) begin
				pending_angles.push_back(kalman_update(s_axis_tdata[ADC_BITS_DEF-1:0]));
				n_samples++;
			end
		end
	end

	// leaves the sample valid high so back-to-back beats need no extra assignment
	task automatic send_sample(input logic [IN_W-1:0] word);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(negedge clk);
		while (pending_angles.size() != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic configure(input logic [11:0] origin, input logic [31:0] slope,
			input logic [15:0] offset, input logic [31:0] meas, input logic [31:0] proc,
			input logic [31:0] init);
		write_reg(CFG_ADC_ORIGIN, {20'd0, origin});
		write_reg(CFG_SLOPE, slope);
		write_reg(CFG_ANGLE_OFFSET, {{16{offset[15]}}, offset});
		write_reg(CFG_MEAS_VAR, meas);
		write_reg(CFG_PROC_VAR, proc);
		write_reg(CFG_INIT_VAR, init);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] pick_variance(input int unsigned small_max);
		case ($urandom_range(5))
			0:       return '0;
			1:       return $urandom;
			2:       return VAR_MAX - $urandom_range(3);
			default: return $urandom_range(small_max);
		endcase
	endfunction

	// seeds with the largest initial variance so the first prediction clips
	task automatic test_seed_and_first_steps();
		configure(12'd2048, 32'd19300, -16'sd1000, 32'h0000_4000, 32'h0000_0100, VAR_MAX);
		send_sample(16'd2048);
		send_sample(16'd0);
		send_sample(16'd4095);
		send_sample(16'd2100);
		drain_results();
	endtask

	task automatic test_mapping_limits();
		configure(12'd0, 32'h7FFF_FFFF, 16'sh7FFF, VAR_ONE, 32'h0000_0400, VAR_ONE);
		send_sample(16'd0);
		send_sample(16'd4095);
		drain_results();
		configure(12'd4095, 32'h8000_0000, 16'h8000, VAR_ONE, 32'h0000_0400, VAR_ONE);
		send_sample(16'd4095);
		send_sample(16'd0);
		drain_results();
		configure(12'd0, 32'h8000_0000, 16'd0, VAR_ONE, 32'h0000_0400, VAR_ONE);
		send_sample(16'd4095);
		drain_results();
		// half a q3.12 step per count: odd offsets land exactly on a tie
		configure(12'd1, 32'h0000_0800, 16'd0, VAR_ONE, 32'h0000_0400, VAR_ONE);
		send_sample(16'd0);
		send_sample(16'd2);
		drain_results();
	endtask

	task automatic test_zero_denominator();
		// full gain empties the variance, then both sides of the sum are zero
		configure(12'd2048, 32'd19000, 16'd0, 32'd0, 32'd0, VAR_ONE);
		send_sample(16'd3000);
		send_sample(16'd1000);
		drain_results();
		configure(12'd2048, 32'd19000, 16'd0, VAR_ONE, 32'd0, VAR_ONE);
		send_sample(16'd1500);
		drain_results();
	endtask

	task automatic test_variance_clip();
		configure(12'd2048, 32'd19000, 16'd100, VAR_MAX, VAR_MAX, VAR_ONE);
		send_sample(16'd500);
		send_sample(16'd3500);
		drain_results();
		configure(12'd2048, 32'd19000, 16'd100, 32'd0, VAR_MAX, VAR_ONE);
		send_sample(16'd4000);
		drain_results();
	endtask

	task automatic test_ignored_inputs();
		configure(12'd1000, 32'd25000, 16'd300, 32'h0000_8000, 32'h0000_0200, VAR_ONE);
		write_reg(CFG_SPARE_LO, $urandom);
		write_reg(CFG_SPARE_HI, $urandom);
		cfg_valid <= 1'b0;
		// pad bits above the converter width must not reach the mapping
		send_sample({4'hF, 12'h5A5});
		send_sample({4'hA, 12'hA5A});
		drain_results();
	endtask

	task automatic test_random(input int src_pct, input int snk_pct, input int count);
		int pos;
		int sample;
		int per_phase;
		logic [31:0] slope;
		per_phase = count / PHASES;
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			if (ph == 0) begin
				configure(12'd4095, 32'h7FFF_FFFF, 16'sh7FFF, VAR_MAX, VAR_MAX, VAR_MAX);
			end else if (ph == 1) begin
				configure(12'd0, 32'h8000_0000, 16'h8000, 32'd0, 32'd0, 32'd0);
			end else begin
				if ($urandom_range(9) < 8)
					slope = $urandom_range(80000) - 40000;
				else
					slope = $urandom;
				configure(12'($urandom_range(4095)), slope, 16'($urandom),
					pick_variance(1 << 20), pick_variance(1 << 16), $urandom);
			end
			pos = $urandom_range(4095);
			for (int i = 0; i < per_phase; i++) begin
				case ($urandom_range(19))
					0, 1: begin
						pos = $urandom_range(4095);
						sample = pos;
					end
					2, 3, 4: sample = $urandom_range(4095);
					default: begin
						// slow knob travel with converter noise on top
						pos = pos + $urandom_range(40) - 20;
						pos = (pos < 0) ? 0 : (pos > 4095) ? 4095 : pos;
						sample = pos + $urandom_range(16) - 8;
						sample = (sample < 0) ? 0 : (sample > 4095) ? 4095 : sample;
					end
				endcase
				send_sample(sample[IN_W-1:0]);
			end
		end
		drain_results();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_seed_and_first_steps();
		test_mapping_limits();
		test_zero_denominator();
		test_variance_clip();
		test_ignored_inputs();
		test_random(32, 70, 618);
		test_random(70, 32, 618);
		test_random(0, 0, 618);
		drain_results();
		repeat (60) @(posedge clk);
		$display("%0d samples, %0d results checked, %0d register writes", n_samples, n_results,
			n_writes);
		$display("seeding, mapping clip and ties, zero gain, variance clip, spare writes, "
			, "random calibration under three pacing mixes");
		if (n_bad == 0) begin
			$display("pot_angle_kalman_filter: match");
		end else begin
			$display("pot_angle_kalman_filter: mismatch");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results pending", pending_angles.size());
		$display("pot_angle_kalman_filter: mismatch");
		$finish;
	end

endmodule
